>>> design/dpaf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpaf_pkg
// Shared widths, character codes and pipeline types of the decimal pair
// ASCII formatter.
// ----------------------------------------------------------------------------
package dpaf_pkg;

    localparam int VALUE_W         = 14;
    localparam int CHAR_W          = 8;
    localparam int BCD_DIGITS      = 5;
    localparam int BCD_W           = 4 * BCD_DIGITS;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DABBLE_STAGES   = (VALUE_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int DIGITS_DEFAULT  = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] ASCII_NEWLINE = 8'd10;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } work_t;

    typedef struct packed {
        work_t a;
        work_t b;
    } pair_work_t;

    function automatic logic [31:0] pow10(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 32'd10;
        end
        return p;
    endfunction

endpackage
`default_nettype wire

>>> design/dpaf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpaf_if
// Valid/ready channels of the formatter: value pairs in, characters out.
// ----------------------------------------------------------------------------
interface pair_if
    import dpaf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink (input valid, input first_value, input second_value, output ready);
endinterface

interface char_if
    import dpaf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink (input valid, input character, input last_char, output ready);
endinterface
`default_nettype wire

>>> design/dpaf_sat_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpaf_sat_stage
// First pipeline stage: clamps both values to the largest printable value
// and seeds the shift-and-add-three work words.
// ----------------------------------------------------------------------------
module dpaf_sat_stage
    import dpaf_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [VALUE_W-1:0] first_value,
    input  wire logic [VALUE_W-1:0] second_value,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      pair_work_t         out_data
);

    localparam logic [31:0] CAP = pow10(DIGITS) - 32'd1;

    logic       valid_reg;
    logic       valid_next;
    pair_work_t data_reg;
    pair_work_t data_next;

    function automatic logic [VALUE_W-1:0] clamp(input logic [VALUE_W-1:0] v);
        logic [31:0] wide;
        wide = {{(32 - VALUE_W){1'b0}}, v};
        if (wide > CAP)
        begin
            return CAP[VALUE_W-1:0];
        end
        return v;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready)
        begin
            valid_next     = in_valid;
            data_next.a.bcd = '0;
            data_next.a.bin = clamp(first_value);
            data_next.b.bcd = '0;
            data_next.b.bin = clamp(second_value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

>>> design/dpaf_dabble_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpaf_dabble_stage
// One register stage of the binary to BCD conversion: NSTEPS
// shift-and-add-three steps on both values.
// ----------------------------------------------------------------------------
module dpaf_dabble_stage
    import dpaf_pkg::*;
#(
    parameter int NSTEPS = STEPS_PER_STAGE
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire pair_work_t in_data,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      pair_work_t out_data
);

    logic       valid_reg;
    logic       valid_next;
    pair_work_t data_reg;
    pair_work_t data_next;

    function automatic work_t dabble(input work_t w);
        work_t r;
        r = w;
        for (int s = 0; s < NSTEPS; s++)
        begin
            for (int k = 0; k < BCD_DIGITS; k++)
            begin
                if (r.bcd[4*k +: 4] >= 4'd5)
                begin
                    r.bcd[4*k +: 4] = r.bcd[4*k +: 4] + 4'd3;
                end
            end
            r = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
        end
        return r;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready)
        begin
            valid_next  = in_valid;
            data_next.a = dabble(in_data.a);
            data_next.b = dabble(in_data.b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

>>> design/dpaf_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpaf_serializer
// Holds one converted pair and sends its line one character a beat
// through an output register.
// ----------------------------------------------------------------------------
module dpaf_serializer
    import dpaf_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [BCD_W-1:0]  first_bcd,
    input  wire logic [BCD_W-1:0]  second_bcd,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic [CHAR_W-1:0] character,
    output      logic              last_char
);

    localparam int LINE_LEN = 2 * DIGITS + 2;
    localparam int POS_W    = $clog2(LINE_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_LEN - 1);

    logic              line_valid_reg;
    logic              line_valid_next;
    logic [BCD_W-1:0]  first_reg;
    logic [BCD_W-1:0]  first_next;
    logic [BCD_W-1:0]  second_reg;
    logic [BCD_W-1:0]  second_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              char_valid_reg;
    logic              char_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              last_reg;
    logic              last_next;
    logic              load_out;
    logic              emit;
    logic              at_end;
    logic [CHAR_W-1:0] sel_char;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [BCD_W-1:0] bcd,
                                                     input int idx);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (k == idx)
            begin
                d = bcd[4*k +: 4];
            end
        end
        return ASCII_ZERO + {{(CHAR_W - 4){1'b0}}, d};
    endfunction

    assign load_out  = !char_valid_reg || out_ready;
    assign emit      = load_out && line_valid_reg;
    assign at_end    = (pos_reg == LAST_POS);
    assign in_ready  = !line_valid_reg || (emit && at_end);
    assign out_valid = char_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

    always_comb
    begin
        int p;
        p = int'(pos_reg);
        if (p < DIGITS)
        begin
            sel_char = digit_char(first_reg, DIGITS - 1 - p);
        end
        else if (p == DIGITS)
        begin
            sel_char = ASCII_SPACE;
        end
        else if (p < LINE_LEN - 1)
        begin
            sel_char = digit_char(second_reg, 2 * DIGITS - p);
        end
        else
        begin
            sel_char = ASCII_NEWLINE;
        end
    end

    always_comb
    begin
        line_valid_next = line_valid_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        pos_next        = pos_reg;
        char_valid_next = char_valid_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        if (emit)
        begin
            if (at_end)
            begin
                line_valid_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        if (in_valid && in_ready)
        begin
            line_valid_next = 1'b1;
            first_next      = first_bcd;
            second_next     = second_bcd;
            pos_next        = '0;
        end
        if (load_out)
        begin
            char_valid_next = line_valid_reg;
            char_next       = sel_char;
            last_next       = at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= 1'b0;
            pos_reg        <= '0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            line_valid_reg <= line_valid_next;
            pos_reg        <= pos_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

endmodule
`default_nettype wire

>>> design/decimal_pair_ascii_formatter_unit.sv
// The unit takes a pair of 14-bit unsigned values in one beat and sends one
// line of 2*DIGITS+2 characters, one a beat: the DIGITS decimal digits of the
// first value with leading zeros, a space, those of the second value and a
// newline, which alone carries last_char; a value beyond 10^DIGITS-1 prints
// as all nines. A pair passes a clamping stage and four conversion stages,
// then the line buffer and the output register of the serialiser. As the
// single character port sends one character a beat, the serialiser takes
// the next pair in the cycle in which the newline of the current one leaves
// the line buffer.
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_pair_ascii_formatter_unit
// Top level: clamp stage, pipelined binary to BCD conversion and the line
// serialiser.
// ----------------------------------------------------------------------------
module decimal_pair_ascii_formatter_unit
    import dpaf_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
)
(
    input wire logic clk,
    input wire logic rst_n,
    pair_if.sink     pair,
    char_if.source   text
);

    logic       stage_valid [DABBLE_STAGES+1];
    logic       stage_ready [DABBLE_STAGES+1];
    pair_work_t stage_data  [DABBLE_STAGES+1];

    dpaf_sat_stage #(
        .DIGITS(DIGITS)
    ) u_sat (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pair.valid),
        .in_ready    (pair.ready),
        .first_value (pair.first_value),
        .second_value(pair.second_value),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_data    (stage_data[0])
    );

    for (genvar k = 0; k < DABBLE_STAGES; k++)
    begin : g_dabble
        localparam int LEFT = VALUE_W - k * STEPS_PER_STAGE;
        localparam int N    = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;

        dpaf_dabble_stage #(
            .NSTEPS(N)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (stage_valid[k]),
            .in_ready (stage_ready[k]),
            .in_data  (stage_data[k]),
            .out_valid(stage_valid[k+1]),
            .out_ready(stage_ready[k+1]),
            .out_data (stage_data[k+1])
        );
    end

    dpaf_serializer #(
        .DIGITS(DIGITS)
    ) u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[DABBLE_STAGES]),
        .in_ready  (stage_ready[DABBLE_STAGES]),
        .first_bcd (stage_data[DABBLE_STAGES].a.bcd),
        .second_bcd(stage_data[DABBLE_STAGES].b.bcd),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .character (text.character),
        .last_char (text.last_char)
    );

endmodule
`default_nettype wire

>>> design/dpaf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpaf_checker
// Port-level checks of the formatter: output beat stability, line length
// and the characters allowed on the output.
// ----------------------------------------------------------------------------
module dpaf_checker
    import dpaf_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [CHAR_W-1:0] character,
    input wire logic              last_char
);

    localparam int LINE_LEN = 2 * DIGITS + 2;
    localparam int CNT_W    = $clog2(LINE_LEN + 1);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(LINE_LEN - 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             beat;

    assign beat = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (beat)
        begin
            count_next = last_char ? '0 : count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat withdrawn while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(character) && $stable(last_char))
        else $error("output payload changed while stalled");

    a_line_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (last_char || count_reg == LAST_POS) |->
            (last_char && count_reg == LAST_POS))
        else $error("line length wrong");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_char && character == ASCII_NEWLINE)
            || (!last_char && character == ASCII_SPACE)
            || (!last_char && character >= ASCII_ZERO && character <= ASCII_ZERO + 8'd9))
        else $error("unexpected character on output");

endmodule

bind decimal_pair_ascii_formatter_unit dpaf_checker #(
    .DIGITS(DIGITS)
) u_dpaf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(text.valid),
    .out_ready(text.ready),
    .character(text.character),
    .last_char(text.last_char)
);
`default_nettype wire
